@@ rtl/ptts_pkg.sv @@
// shared types and constants of the periodic task table scheduler
package ptts_pkg;

    // table depth and the width of a counter that can hold it
    localparam int MAX_TASKS = 8;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // request operation codes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_FIRE      = 3'd0,
        KIND_OK        = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_DONE      = 3'd4
    } kind_t;

    // request payload
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  task_tag;
        logic [31:0] period;
        logic [7:0]  run_limit;
        logic        asleep;
    } req_t;

    // result payload
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] fired_tag;
        logic       last;
    } rsp_t;

    // one task entry as held by a cell
    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] period;
        logic [31:0] idle;
        logic [7:0]  runs;
        logic [7:0]  limit;
        logic        asleep;
    } slot_t;

    // what a cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_WRAP
    } cell_cmd_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } state_t;

endpackage

@@ rtl/ptts_req_if.sv @@
// request channel of the task scheduler
interface ptts_req_if;
    logic            valid;
    logic            ready;
    ptts_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ptts_rsp_if.sv @@
// result channel of the task scheduler
interface ptts_rsp_if;
    logic            valid;
    logic            ready;
    ptts_pkg::rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ptts_cell.sv @@
// one slot of the task table chain
module ptts_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptts_pkg::cell_cmd_t cmd,
    input  ptts_pkg::slot_t     load_rec,
    input  ptts_pkg::slot_t     right_rec,
    input  logic                right_valid,
    input  ptts_pkg::slot_t     wrap_rec,
    output ptts_pkg::slot_t     rec,
    output logic                valid
);

    ptts_pkg::slot_t rec_reg;
    logic            valid_reg;

    // occupancy bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd)
                ptts_pkg::CELL_HOLD:  valid_reg <= valid_reg;
                ptts_pkg::CELL_LOAD:  valid_reg <= 1'b1;
                ptts_pkg::CELL_SHIFT: valid_reg <= right_valid;
                ptts_pkg::CELL_WRAP:  valid_reg <= 1'b1;
                default:              valid_reg <= valid_reg;
            endcase
        end
    end

    // task contents
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            ptts_pkg::CELL_HOLD:  rec_reg <= rec_reg;
            ptts_pkg::CELL_LOAD:  rec_reg <= load_rec;
            ptts_pkg::CELL_SHIFT: rec_reg <= right_rec;
            ptts_pkg::CELL_WRAP:  rec_reg <= wrap_rec;
            default:              rec_reg <= rec_reg;
        endcase
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

endmodule

@@ rtl/periodic_task_table_scheduler.sv @@
// periodic task table scheduler: cell chain and its sequencer
//
//  channel | role   | payload
//  --------+--------+---------------------------------------------
//  req     | sink   | op, task_tag, period, run_limit, asleep
//  rsp     | source | kind, fired_tag, last
//
// add and remove give their result in the output register.
// a tick accepts the request, then the chain rotates each task through the head cell
// in turn, stalling while a result is held, and then gives the done result.
// reset clears the occupancy bits, the task count, the sequencer and the output valid.
// a held result stalls the sequencer; a new request is taken only when idle and the
// output register is free or being drained.
module periodic_task_table_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    ptts_req_if.sink    req,
    ptts_rsp_if.source  rsp
);

    localparam int N = ptts_pkg::MAX_TASKS;
    localparam int W = ptts_pkg::CNT_W;

    ptts_pkg::slot_t     cell_rec   [N];
    ptts_pkg::slot_t     right_rec  [N];
    logic [N-1:0]        right_valid;
    logic [N-1:0]        cell_valid;
    ptts_pkg::cell_cmd_t cell_cmd   [N];
    ptts_pkg::slot_t     load_rec;
    ptts_pkg::slot_t     wrap_rec;

    ptts_pkg::state_t    state_reg, state_next;
    logic [W-1:0]        count_reg, count_next;
    logic [W-1:0]        remaining_reg, remaining_next;
    logic                out_valid_reg;
    ptts_pkg::rsp_t      out_data_reg;
    logic                out_load;
    ptts_pkg::rsp_t      out_data;
    logic                out_free;
    logic                req_fire;

    logic [31:0]         head_idle_inc;
    logic [7:0]          head_runs_inc;
    logic                head_fire;
    logic                head_drop;
    logic [N-1:0]        tag_match;
    logic [N-1:0]        shift_mask;
    logic                tag_found;

    assign out_free = !out_valid_reg || rsp.ready;
    assign req_fire = req.valid && req.ready;

    // chain of cells, each fed by its right neighbor; the last cell is fed an empty slot
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        if (g + 1 < N)
        begin : g_mid
            assign right_rec[g]   = cell_rec[g + 1];
            assign right_valid[g] = cell_valid[g + 1];
        end
        else
        begin : g_end
            assign right_rec[g]   = '0;
            assign right_valid[g] = 1'b0;
        end

        ptts_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd[g]),
            .load_rec    (load_rec),
            .right_rec   (right_rec[g]),
            .right_valid (right_valid[g]),
            .wrap_rec    (wrap_rec),
            .rec         (cell_rec[g]),
            .valid       (cell_valid[g])
        );
    end

    // new task entry from an add request
    always_comb
    begin
        load_rec        = '0;
        load_rec.tag    = req.data.task_tag;
        load_rec.period = req.data.period;
        load_rec.limit  = req.data.run_limit;
        load_rec.asleep = req.data.asleep;
    end

    // head cell evaluation during a tick
    always_comb
    begin
        head_idle_inc = (cell_rec[0].idle == '1) ? cell_rec[0].idle
                                                 : cell_rec[0].idle + 32'd1;
        head_runs_inc = (cell_rec[0].runs == '1) ? cell_rec[0].runs
                                                 : cell_rec[0].runs + 8'd1;
        head_fire = !cell_rec[0].asleep && (head_idle_inc >= cell_rec[0].period);
        head_drop = head_fire && (cell_rec[0].limit != 8'd0)
                    && (head_runs_inc >= cell_rec[0].limit);
        wrap_rec      = cell_rec[0];
        wrap_rec.idle = head_fire ? head_idle_inc - cell_rec[0].period : head_idle_inc;
        if (head_fire)
        begin
            wrap_rec.runs = head_runs_inc;
        end
    end

    // first matching tag and the cells at or after it
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            tag_match[j] = cell_valid[j] && (cell_rec[j].tag == req.data.task_tag);
        end
        shift_mask[0] = tag_match[0];
        for (int j = 1; j < N; j++)
        begin
            shift_mask[j] = shift_mask[j - 1] || tag_match[j];
        end
        tag_found = |tag_match;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptts_pkg::ST_IDLE:
            begin
                if (req_fire && (req.data.op == ptts_pkg::OP_TICK))
                begin
                    state_next = ptts_pkg::ST_TICK;
                end
            end
            ptts_pkg::ST_TICK:
            begin
                if (out_free && (remaining_reg == '0))
                begin
                    state_next = ptts_pkg::ST_IDLE;
                end
            end
            default: state_next = ptts_pkg::ST_IDLE;
        endcase
    end

    // cell commands, counters and results
    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            cell_cmd[j] = ptts_pkg::CELL_HOLD;
        end
        count_next     = count_reg;
        remaining_next = remaining_reg;
        out_load       = 1'b0;
        out_data       = '0;
        req.ready      = 1'b0;

        unique case (state_reg)
            ptts_pkg::ST_IDLE:
            begin
                req.ready = out_free;
                if (req_fire)
                begin
                    unique case (req.data.op)
                        ptts_pkg::OP_TICK:
                        begin
                            remaining_next = count_reg;
                        end
                        ptts_pkg::OP_ADD:
                        begin
                            out_load           = 1'b1;
                            out_data.fired_tag = req.data.task_tag;
                            out_data.last      = 1'b1;
                            if (count_reg < W'(N))
                            begin
                                for (int j = 0; j < N; j++)
                                begin
                                    if (W'(j) == count_reg)
                                    begin
                                        cell_cmd[j] = ptts_pkg::CELL_LOAD;
                                    end
                                end
                                count_next    = count_reg + W'(1);
                                out_data.kind = ptts_pkg::KIND_OK;
                            end
                            else
                            begin
                                out_data.kind = ptts_pkg::KIND_FULL;
                            end
                        end
                        ptts_pkg::OP_REMOVE:
                        begin
                            out_load           = 1'b1;
                            out_data.fired_tag = req.data.task_tag;
                            out_data.last      = 1'b1;
                            if (tag_found)
                            begin
                                for (int j = 0; j < N; j++)
                                begin
                                    if (shift_mask[j])
                                    begin
                                        cell_cmd[j] = ptts_pkg::CELL_SHIFT;
                                    end
                                end
                                count_next    = count_reg - W'(1);
                                out_data.kind = ptts_pkg::KIND_OK;
                            end
                            else
                            begin
                                out_data.kind = ptts_pkg::KIND_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ptts_pkg::ST_TICK:
            begin
                if (out_free)
                begin
                    if (remaining_reg == '0)
                    begin
                        // closing result of the tick
                        out_load      = 1'b1;
                        out_data.kind = ptts_pkg::KIND_DONE;
                        out_data.last = 1'b1;
                    end
                    else
                    begin
                        // rotate the head task to the tail, or drop it
                        for (int j = 0; j < N; j++)
                        begin
                            if (head_drop || (W'(j + 1) < count_reg))
                            begin
                                cell_cmd[j] = ptts_pkg::CELL_SHIFT;
                            end
                            else if (W'(j + 1) == count_reg)
                            begin
                                cell_cmd[j] = ptts_pkg::CELL_WRAP;
                            end
                        end
                        remaining_next = remaining_reg - W'(1);
                        if (head_drop)
                        begin
                            count_next = count_reg - W'(1);
                        end
                        if (head_fire)
                        begin
                            out_load           = 1'b1;
                            out_data.kind      = ptts_pkg::KIND_FIRE;
                            out_data.fired_tag = cell_rec[0].tag;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptts_pkg::ST_IDLE;
            count_reg     <= '0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // occupied cells always match the task count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("occupancy bits disagree with task count");

    // tasks left to visit never exceed the tasks held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptts_pkg::ST_TICK) |-> (remaining_reg <= count_reg))
        else $error("tick visit count exceeds task count");

    // the done result closes the tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (out_data.kind == ptts_pkg::KIND_DONE))
        |=> (state_reg == ptts_pkg::ST_IDLE))
        else $error("sequencer still busy after tick done");

endmodule

@@ sim/periodic_task_table_scheduler_test.sv @@
// regression bench for the periodic task table scheduler, self-checking against a task table model
`timescale 1ns / 1ps

module periodic_task_table_scheduler_test;

    // opcode the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // cycles with no request or result moving before the run is declared hung
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 80;
    localparam int RUN_TICKS = 24;
    localparam int RSP_HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    ptts_req_if req_ch ();
    ptts_rsp_if rsp_ch ();

    periodic_task_table_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // task table as the block should hold it, and the results still owed
    ptts_pkg::slot_t task_table[$];
    ptts_pkg::rsp_t  awaited_results[$];

    int unsigned failures = 0;
    int unsigned tick_count = 0;
    int unsigned add_count = 0;
    int unsigned remove_count = 0;
    int unsigned unused_count = 0;
    int unsigned results_checked = 0;
    int unsigned fires_seen = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rsp_hold_len = 0;
    bit          no_gaps = 1'b0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // record one result the block owes
    function automatic void owe_result(input ptts_pkg::kind_t kind, input logic [7:0] tag,
                                       input logic fin);
        ptts_pkg::rsp_t r;
        r.kind      = kind;
        r.fired_tag = tag;
        r.last      = fin;
        awaited_results.push_back(r);
    endfunction

    // advance the task table by one accepted request and owe its results
    function automatic void apply_to_table(input ptts_pkg::req_t r);
        ptts_pkg::slot_t s;
        int    i;
        int    j;
        case (r.op)
            ptts_pkg::OP_ADD:
            begin
                if (task_table.size() >= ptts_pkg::MAX_TASKS)
                begin
                    owe_result(ptts_pkg::KIND_FULL, r.task_tag, 1'b1);
                end
                else
                begin
                    s.tag    = r.task_tag;
                    s.period = r.period;
                    s.idle   = '0;
                    s.runs   = '0;
                    s.limit  = r.run_limit;
                    s.asleep = r.asleep;
                    task_table.push_back(s);
                    owe_result(ptts_pkg::KIND_OK, r.task_tag, 1'b1);
                end
            end
            ptts_pkg::OP_REMOVE:
            begin
                // earliest task with this tag goes, the rest close up
                i = 0;
                while (i < task_table.size() && task_table[i].tag != r.task_tag)
                    i++;
                if (i < task_table.size())
                begin
                    task_table.delete(i);
                    owe_result(ptts_pkg::KIND_OK, r.task_tag, 1'b1);
                end
                else
                begin
                    owe_result(ptts_pkg::KIND_NOT_FOUND, r.task_tag, 1'b1);
                end
            end
            ptts_pkg::OP_TICK:
            begin
                // every task ages by one, saturating
                for (j = 0; j < task_table.size(); j++)
                begin
                    s = task_table[j];
                    if (s.idle != 32'hFFFF_FFFF)
                        s.idle = s.idle + 32'd1;
                    task_table[j] = s;
                end
                // visit in order, a task that hits its limit drops out in place
                i = 0;
                while (i < task_table.size())
                begin
                    s = task_table[i];
                    if (s.asleep || s.idle < s.period)
                    begin
                        i++;
                    end
                    else
                    begin
                        s.idle = s.idle - s.period;
                        if (s.runs != 8'hFF)
                            s.runs = s.runs + 8'd1;
                        owe_result(ptts_pkg::KIND_FIRE, s.tag, 1'b0);
                        if (s.limit != 8'd0 && s.runs >= s.limit)
                        begin
                            task_table.delete(i);
                        end
                        else
                        begin
                            task_table[i] = s;
                            i++;
                        end
                    end
                end
                owe_result(ptts_pkg::KIND_DONE, 8'h00, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    // offer one request after a random gap and wait until it is taken
    task automatic send_request(input logic [1:0] op, input logic [7:0] tag,
                                input logic [31:0] period, input logic [7:0] limit,
                                input logic asleep);
        ptts_pkg::req_t r;
        int unsigned    gap;
        r.op        = op;
        r.task_tag  = tag;
        r.period    = period;
        r.run_limit = limit;
        r.asleep    = asleep;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_to_table(r);
        case (op)
            ptts_pkg::OP_TICK:   tick_count++;
            ptts_pkg::OP_ADD:    add_count++;
            ptts_pkg::OP_REMOVE: remove_count++;
            default:             unused_count++;
        endcase
    endtask

    // stop offering and wait for every owed result
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // empty the table through the front entry
    task automatic clear_table();
        while (task_table.size() > 0)
            send_request(ptts_pkg::OP_REMOVE, task_table[0].tag, 32'd0, 8'd0, 1'b0);
    endtask

    // ticks and removes against an empty table, and the ignored opcode
    task automatic test_empty_table();
        send_request(ptts_pkg::OP_TICK, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_request(ptts_pkg::OP_REMOVE, 8'h00, 32'd0, 8'd0, 1'b0);
        send_request(OP_UNUSED, 8'hA5, 32'h5A5A_A5A5, 8'h3C, 1'b1);
        send_request(ptts_pkg::OP_TICK, 8'h00, 32'd0, 8'd0, 1'b0);
    endtask

    // field extremes, duplicate tags, period zero and sleeping tasks
    task automatic test_add_remove();
        send_request(ptts_pkg::OP_ADD, 8'h00, 32'd0, 8'd0, 1'b0);
        send_request(ptts_pkg::OP_ADD, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_request(ptts_pkg::OP_ADD, 8'h5A, 32'd1, 8'd3, 1'b0);
        send_request(ptts_pkg::OP_ADD, 8'h5A, 32'd2, 8'd0, 1'b0);
        send_request(ptts_pkg::OP_REMOVE, 8'h5A, 32'd0, 8'd0, 1'b0);
        send_request(ptts_pkg::OP_TICK, 8'd0, 32'd0, 8'd0, 1'b0);
        send_request(ptts_pkg::OP_TICK, 8'd0, 32'd0, 8'd0, 1'b0);
        send_request(ptts_pkg::OP_REMOVE, 8'hFF, 32'd0, 8'd0, 1'b0);
        send_request(ptts_pkg::OP_REMOVE, 8'h77, 32'd0, 8'd0, 1'b0);
        clear_table();
    endtask

    // fill to capacity, overflow once, then let run limits drop tasks
    task automatic test_full_table();
        int k;
        for (k = 0; k < ptts_pkg::MAX_TASKS; k++)
            send_request(ptts_pkg::OP_ADD, 8'h10 + k[7:0], 32'(k % 3),
                         (k < 2) ? 8'(k + 1) : 8'd0, k == ptts_pkg::MAX_TASKS - 1);
        send_request(ptts_pkg::OP_ADD, 8'hEE, 32'd1, 8'd1, 1'b0);
        send_request(ptts_pkg::OP_TICK, 8'd0, 32'd0, 8'd0, 1'b0);
        send_request(ptts_pkg::OP_TICK, 8'd0, 32'd0, 8'd0, 1'b0);
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        int k;
        no_gaps = 1'b1;
        rsp_hold_len = RSP_HOLD_CYCLES;
        for (k = 0; k < 12; k++)
        begin
            if (k % 3 == 2)
                send_request(ptts_pkg::OP_ADD, 8'h60 + k[7:0], 32'd0, 8'd2, 1'b0);
            else
                send_request(ptts_pkg::OP_TICK, 8'd0, 32'd0, 8'd0, 1'b0);
        end
        wait_for_results();
        no_gaps = 1'b0;
    endtask

    // unlimited, largest-limit, sleeping and slow tasks over a run of ticks
    task automatic test_run_saturation();
        clear_table();
        send_request(ptts_pkg::OP_ADD, 8'h11, 32'd0, 8'd0, 1'b0);
        send_request(ptts_pkg::OP_ADD, 8'h22, 32'd0, 8'hFF, 1'b0);
        send_request(ptts_pkg::OP_ADD, 8'h33, 32'd0, 8'd0, 1'b1);
        send_request(ptts_pkg::OP_ADD, 8'h44, 32'd3, 8'd0, 1'b0);
        repeat (RUN_TICKS)
            send_request(ptts_pkg::OP_TICK, 8'd0, 32'd0, 8'd0, 1'b0);
        clear_table();
    endtask

    // random mix of ticks, adds, removes and unused opcodes, mostly on a small tag pool
    task automatic test_random_mix();
        int unsigned n;
        int unsigned pick;
        logic [7:0]  tag;
        logic [31:0] period;
        logic [7:0]  limit;
        logic        asleep;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            no_gaps = (n >= 40 && n < 70);
            pick = $urandom_range(0, 99);
            tag = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 19))
                0, 1, 2:    period = $urandom();
                3, 4, 5, 6: period = $urandom_range(5, 20);
                default:    period = $urandom_range(0, 4);
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2:          limit = 8'($urandom_range(0, 255));
                3, 4, 5, 6, 7, 8: limit = 8'($urandom_range(1, 4));
                default:          limit = 8'd0;
            endcase
            asleep = ($urandom_range(0, 99) < 15);
            if (pick < 5)
            begin
                send_request(OP_UNUSED, tag, period, limit, asleep);
            end
            else
            begin
                if (pick < 45)
                begin
                    send_request(ptts_pkg::OP_TICK, tag, period, limit, asleep);
                end
                else if (pick < 78)
                begin
                    send_request(ptts_pkg::OP_ADD, tag, period, limit, asleep);
                end
                else
                begin
                    // mostly aim at a task that exists
                    if (task_table.size() > 0 && $urandom_range(0, 3) != 0)
                        tag = task_table[$urandom_range(0, task_table.size() - 1)].tag;
                    send_request(ptts_pkg::OP_REMOVE, tag, period, limit, asleep);
                end
                n++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // result receiver: random stalls per result, one long hold on demand
    initial
    begin : result_sink
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_len > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_hold_len) @(posedge clk);
                rsp_hold_len = 0;
            end
            else
            begin
                stall = no_gaps ? 0 : $urandom_range(0, 17);
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    // compare each accepted result with the oldest owed one
    always @(posedge clk)
    begin : check_results
        ptts_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with none owed: kind %0d fired_tag %0d last %0d",
                       rsp_ch.data.kind, rsp_ch.data.fired_tag, rsp_ch.data.last);
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (want.kind == ptts_pkg::KIND_FIRE)
                    fires_seen++;
                if (rsp_ch.data.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, rsp_ch.data.kind);
                    failures++;
                end
                if (rsp_ch.data.fired_tag !== want.fired_tag)
                begin
                    $error("fired_tag: expected %0d, actual %0d", want.fired_tag,
                           rsp_ch.data.fired_tag);
                    failures++;
                end
                if (rsp_ch.data.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, rsp_ch.data.last);
                    failures++;
                end
            end
        end
    end

    // hang detection: too long with nothing moving on either channel
    always @(posedge clk)
    begin
        if (rst_n && ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d results still owed", quiet_cycles,
                     awaited_results.size());
            $display("periodic_task_table_scheduler regression: fail");
            $finish;
        end
    end

    // reset, then the tests in turn
    initial
    begin : run_regression
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_add_remove();
        test_full_table();
        test_backpressure();
        test_run_saturation();
        test_random_mix();

        wait_for_results();
        repeat (3 * ptts_pkg::MAX_TASKS) @(posedge clk);

        $display("covered %0d ticks, %0d adds, %0d removes and %0d unused opcodes",
                 tick_count, add_count, remove_count, unused_count);
        $display("checked %0d results, %0d of them task fires, with %0d mismatches",
                 results_checked, fires_seen, failures);
        if (failures == 0)
            $display("periodic_task_table_scheduler regression: pass");
        else
            $display("periodic_task_table_scheduler regression: fail");
        $finish;
    end

endmodule
